// ===== design/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int PAD_W  = 3;

  // work register: up to 7 pending bits plus a full-width code
  localparam int WORK_W = CODE_W + BYTE_W;
  localparam int WCNT_W = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int DEFAULT_SYMBOL_COUNT = 256;
  localparam int DEFAULT_MAX_CODE_LEN = 32;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [PAD_W-1:0]  pad_bits;
    logic              last;
  } result_t;

  // command from the front end to the packer
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/huffman_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Huffman encoder back end: code table plus MSB-first byte packer.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid/item_ready/item): op 0 loads a table entry,
//    op 1 encodes a symbol, op 2 flushes the partial byte. Op 3 and symbols
//    beyond the table are dropped.
//  - result channel (result_valid/result_ready/result): one byte per
//    transaction, earliest bit in bit 7. Flush bytes carry last and a pad count.
//  - An encode that completes a byte passes the table read, the queue write,
//    the merge and the output register, in that order, before result_valid
//    rises.
//  - Throughput: an item is taken every cycle while the command queue has
//    room. The packer merges each code and then emits the bytes it completes
//    before it takes the next command; bytes leave at up to one per cycle
//    while the receiver takes them.
//  - When the receiver stalls, the output register holds, the packer stops,
//    the four-entry queue fills and then item_ready drops.
//  - Reset clears the pending bits, the queue and the output valid. The code
//    table is not cleared; encode only symbols that have been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_unit #(
  parameter int SYMBOL_COUNT = hcbp_pkg::DEFAULT_SYMBOL_COUNT,
  parameter int MAX_CODE_LEN = hcbp_pkg::DEFAULT_MAX_CODE_LEN
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire hcbp_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output hcbp_pkg::result_t     result
);

  // front end to queue
  logic           cmd_valid;
  logic           cmd_ready;
  hcbp_pkg::cmd_t cmd;

  // queue to packer
  logic           q_valid;
  logic           q_ready;
  hcbp_pkg::cmd_t q_cmd;

  // classifier and code table lookup
  hcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // decouples lookup from packing so each side stalls on its own
  hcbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // byte packer with output register
  hcbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .cmd          (q_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Full bytes carry no padding; flush bytes always pad at least one bit.
  a_pad_matches_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == (result.pad_bits != '0)))
    else $error("pad count does not match last flag");

  // A stalled command from the front end must hold until queued.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("front end command changed while stalled");

  // The front end only back-pressures when the queue is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> cmd_valid && !cmd_ready)
    else $error("item channel stalled without a full queue");

endmodule

`default_nettype wire

// ===== design/hcbp_front.sv =====
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts items, owns the code table, turns encodes and flushes into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_front #(
  parameter int SYMBOL_COUNT = hcbp_pkg::DEFAULT_SYMBOL_COUNT,
  parameter int MAX_CODE_LEN = hcbp_pkg::DEFAULT_MAX_CODE_LEN
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire hcbp_pkg::item_t item,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output hcbp_pkg::cmd_t      cmd
);

  localparam int CAP   = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;
  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [CAP-1:0]               code_mem [SYMBOL_COUNT];
  logic [hcbp_pkg::LEN_W-1:0]   len_mem  [SYMBOL_COUNT];

  logic [CAP-1:0]               rd_code;
  logic [hcbp_pkg::LEN_W-1:0]   rd_len;
  logic                         s1_valid;
  logic                         s1_flush;

  logic                         accept;
  logic                         sym_ok;
  logic [IDX_W-1:0]             idx;
  logic [hcbp_pkg::LEN_W-1:0]   len_sat;
  logic [hcbp_pkg::CODE_W-1:0]  code_masked;
  logic                         is_load;
  logic                         keep;

  assign item_ready = !s1_valid || cmd_ready;
  assign accept     = item_valid && item_ready;
  assign sym_ok     = {1'b0, item.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
  assign idx        = item.symbol[IDX_W-1:0];
  assign is_load    = item.op == hcbp_pkg::OP_LOAD;
  assign keep       = ((item.op == hcbp_pkg::OP_ENCODE) && sym_ok)
                   || (item.op == hcbp_pkg::OP_FLUSH);

  always_comb begin
    len_sat = (item.code_length > hcbp_pkg::LEN_W'(CAP)) ? hcbp_pkg::LEN_W'(CAP)
                                                          : item.code_length;
    // drop code bits above the length so the packer can OR codes in
    code_masked = item.code_value & ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);
  end

  // code table: one write port, registered read
  always_ff @(posedge clk) begin
    if (accept && is_load && sym_ok) begin
      code_mem[idx] <= code_masked[CAP-1:0];
      len_mem[idx]  <= len_sat;
    end
    if (accept) begin
      rd_code <= code_mem[idx];
      rd_len  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else if (accept) begin
      s1_valid <= keep;
      s1_flush <= item.op == hcbp_pkg::OP_FLUSH;
    end else if (cmd_ready) begin
      s1_valid <= 1'b0;
    end
  end

  assign cmd_valid  = s1_valid;
  assign cmd.flush  = s1_flush;
  assign cmd.code   = hcbp_pkg::CODE_W'(rd_code);
  assign cmd.len    = rd_len;

endmodule

`default_nettype wire

// ===== design/hcbp_queue.sv =====
// ----------------------------------------------------------------------------
// hcbp_queue
// Small command FIFO between the front end and the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire hcbp_pkg::cmd_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output hcbp_pkg::cmd_t      pop_data
);

  hcbp_pkg::cmd_t                entries [hcbp_pkg::QUEUE_DEPTH];
  logic [hcbp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [hcbp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [hcbp_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  assign push_ready = count != hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hcbp_back.sv =====
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: merges codes in a work register, emits a byte a cycle when free.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire hcbp_pkg::cmd_t  cmd,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output hcbp_pkg::result_t    result
);

  // work holds the pending bits left aligned; bits below work_cnt are zero
  logic [hcbp_pkg::WORK_W-1:0] work;
  logic [hcbp_pkg::WCNT_W-1:0] work_cnt;

  logic                        out_free;
  logic                        has_byte;
  logic                        emit_full;
  logic                        emit_flush;
  logic [hcbp_pkg::WCNT_W-1:0] shamt;
  logic [hcbp_pkg::WORK_W-1:0] code_aligned;

  assign out_free  = !result_valid || result_ready;
  assign has_byte  = work_cnt >= hcbp_pkg::WCNT_W'(hcbp_pkg::BYTE_W);
  assign emit_full = has_byte && out_free;

  // take a command only once fewer than eight bits remain
  assign cmd_ready = !has_byte && (!cmd.flush || work_cnt == '0 || out_free);
  assign emit_flush = cmd_valid && cmd_ready && cmd.flush && work_cnt != '0;

  assign shamt        = hcbp_pkg::WCNT_W'(hcbp_pkg::WORK_W) - work_cnt - cmd.len;
  assign code_aligned = hcbp_pkg::WORK_W'(cmd.code) << shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      work         <= '0;
      work_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit_full || emit_flush) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (emit_full) begin
        work         <= work << hcbp_pkg::BYTE_W;
        work_cnt     <= work_cnt - hcbp_pkg::WCNT_W'(hcbp_pkg::BYTE_W);
      end else if (cmd_valid && cmd_ready) begin
        if (cmd.flush) begin
          work     <= '0;
          work_cnt <= '0;
        end else begin
          work     <= work | code_aligned;
          work_cnt <= work_cnt + cmd.len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_full) begin
      result.out_byte <= work[hcbp_pkg::WORK_W-1 -: hcbp_pkg::BYTE_W];
      result.pad_bits <= '0;
      result.last     <= 1'b0;
    end else if (emit_flush) begin
      result.out_byte <= work[hcbp_pkg::WORK_W-1 -: hcbp_pkg::BYTE_W];
      result.pad_bits <= hcbp_pkg::PAD_W'(4'(hcbp_pkg::BYTE_W) - {1'b0, work_cnt[2:0]});
      result.last     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Huffman code bit packer: table loads, symbol encodes and
// flushes are driven over the item channel and every output byte is checked
// against a cycle-free predictor of the packing.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  // stored code length saturates at the smaller of the parameter and the
  // code field width
  localparam int LEN_CAP = (DEFAULT_MAX_CODE_LEN < CODE_W) ? DEFAULT_MAX_CODE_LEN : CODE_W;
  localparam int RANDOM_ITEMS = 300;
  localparam int HOLD_CYCLES  = 400;
  // no transaction on either side for this many cycles ends the run
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  // op code with no function; the block drops it
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // --------------------------------------------------------------------------
  // Byte predictor and expected-byte store
  // --------------------------------------------------------------------------
  class byte_scoreboard;
    logic [CODE_W-1:0] code_tab [DEFAULT_SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_tab  [DEFAULT_SYMBOL_COUNT];
    logic [BYTE_W-1:0] acc;
    int                fill;
    result_t           expected_bytes [$];
    int                errors;
    int                bytes_seen;
    int                last_seen;

    function new();
      acc        = '0;
      fill       = 0;
      errors     = 0;
      bytes_seen = 0;
      last_seen  = 0;
    endfunction

    // update the model with one accepted item and queue the bytes it causes
    function void note_item(item_t it);
      result_t r;
      int      len;
      case (it.op)
        OP_LOAD: begin
          if (int'(it.symbol) < DEFAULT_SYMBOL_COUNT) begin
            code_tab[it.symbol] = it.code_value;
            len_tab[it.symbol]  = (int'(it.code_length) > LEN_CAP) ?
                                  LEN_W'(LEN_CAP) : it.code_length;
          end
        end
        OP_ENCODE: begin
          if (int'(it.symbol) < DEFAULT_SYMBOL_COUNT) begin
            len = int'(len_tab[it.symbol]);
            for (int i = len; i > 0; i--) begin
              if (code_tab[it.symbol][i-1])
                acc[7-fill] = 1'b1;
              if (fill == 7) begin
                r.out_byte = acc;
                r.pad_bits = '0;
                r.last     = 1'b0;
                expected_bytes.push_back(r);
                acc  = '0;
                fill = 0;
              end else begin
                fill++;
              end
            end
          end
        end
        OP_FLUSH: begin
          if (fill != 0) begin
            r.out_byte = acc;
            r.pad_bits = PAD_W'(8 - fill);
            r.last     = 1'b1;
            expected_bytes.push_back(r);
            acc  = '0;
            fill = 0;
          end
        end
        default: ;  // unused op: dropped
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t unexpected byte: expected none, got byte %02h pad %0d last %0d",
                 $time, got.out_byte, got.pad_bits, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      bytes_seen++;
      if (got.last)
        last_seen++;
      if (got.out_byte !== want.out_byte || got.pad_bits !== want.pad_bits ||
          got.last !== want.last) begin
        errors++;
        $display("%0t byte mismatch: expected byte %02h pad %0d last %0d, got byte %02h pad %0d last %0d",
                 $time, want.out_byte, want.pad_bits, want.last,
                 got.out_byte, got.pad_bits, got.last);
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  byte_scoreboard sb = new();

  // symbols that hold a loaded entry; only these are ever encoded
  bit       loaded [DEFAULT_SYMBOL_COUNT];
  int       loaded_syms [$];
  int       items_in     = 0;
  int       input_stalls = 0;
  bit       hold_req     = 1'b0;
  bit       hold_done    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  huffman_code_bit_packer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 60);
  endfunction

  // code length: mostly short codes, some long, some beyond the cap
  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return '0;
    else if (r < 70)
      return LEN_W'($urandom_range(1, 12));
    else if (r < 90)
      return LEN_W'($urandom_range(13, 32));
    else
      return LEN_W'($urandom_range(33, 63));
  endfunction

  function automatic item_t make_item(logic [OP_W-1:0] op, int sym,
                                      logic [CODE_W-1:0] val, logic [LEN_W-1:0] len);
    item_t it;
    it.op          = op;
    it.symbol      = SYM_W'(sym);
    it.code_value  = val;
    it.code_length = len;
    return it;
  endfunction

  function automatic item_t rand_encode();
    return make_item(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                     $urandom(), LEN_W'($urandom()));
  endfunction

  // offer one transaction after an optional gap and hold it until taken;
  // valid only drops when a gap follows, so back-to-back items keep it high
  task automatic send_item(item_t it, int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do begin
      @(posedge clk);
      if (!item_ready)
        input_stalls++;
    end while (!item_ready);
    if (it.op == OP_LOAD && int'(it.symbol) < DEFAULT_SYMBOL_COUNT &&
        !loaded[it.symbol]) begin
      loaded[it.symbol] = 1'b1;
      loaded_syms.push_back(int'(it.symbol));
    end
    sb.note_item(it);
    items_in++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the queue fills and item_ready drops
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        gap = idle_len();
        if (gap > 0) begin
          result_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // every byte taken on the result channel is checked against the oldest one due
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result(result);
  end

  // watchdog: counts cycles with no transaction on either channel
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t watchdog: no transaction for %0d cycles, %0d bytes outstanding",
             $time, STALL_LIMIT, sb.outstanding());
    $display("tb_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int    n;
    int    r;
    int    sym;
    item_t it;

    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flush and unused op first, nothing should come out
    send_item(make_item(OP_FLUSH, 0, '0, '0), 0);
    send_item(make_item(OP_SPARE, 255, 32'hFFFF_FFFF, 6'h3F), 0);
    // table extremes: zero length, full 32-bit code, over-long length,
    // single bit, junk above the code length
    send_item(make_item(OP_LOAD, 0,   32'hFFFF_FFFF, 6'd0), 0);
    send_item(make_item(OP_LOAD, 255, 32'hFFFF_FFFF, 6'd32), 1);
    send_item(make_item(OP_LOAD, 1,   32'hA5A5_A5A5, 6'd63), 0);
    send_item(make_item(OP_LOAD, 2,   32'h0000_0001, 6'd1), 0);
    send_item(make_item(OP_LOAD, 3,   32'hFFFF_FF55, 6'd7), 2);
    send_item(make_item(OP_LOAD, 4,   32'h0000_0000, 6'd8), 0);
    send_item(make_item(OP_LOAD, 5,   32'h1234_5678, 6'd33), 0);
    // zero-length encode, then four full bytes from one code
    send_item(make_item(OP_ENCODE, 0,   '0, '0), 0);
    send_item(make_item(OP_ENCODE, 255, '0, '0), 0);
    // one bit then flush: seven pad bits
    send_item(make_item(OP_ENCODE, 2, '0, '0), 0);
    send_item(make_item(OP_FLUSH,  0, '0, '0), 0);
    // seven pending bits plus a 32-bit code: four bytes, seven left over
    send_item(make_item(OP_ENCODE, 3,   '0, '0), 0);
    send_item(make_item(OP_ENCODE, 255, '0, '0), 0);
    send_item(make_item(OP_ENCODE, 1,   '0, '0), 3);
    send_item(make_item(OP_ENCODE, 2,   '0, '0), 0);
    send_item(make_item(OP_ENCODE, 4,   '0, '0), 0);
    send_item(make_item(OP_FLUSH,  0,   '0, '0), 0);
    send_item(make_item(OP_ENCODE, 3,   '0, '0), 0);
    send_item(make_item(OP_FLUSH,  0,   '0, '0), 0);
    send_item(make_item(OP_ENCODE, 5,   '0, '0), 0);
    send_item(make_item(OP_FLUSH,  0,   '0, '0), 1);

    // random: populate part of the table first
    repeat (12)
      send_item(make_item(OP_LOAD, $urandom_range(0, 255), $urandom(), pick_len()), idle_len());

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == RANDOM_ITEMS / 3)
        hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        sym = $urandom_range(0, 255);
        it  = make_item(OP_LOAD, sym, $urandom(), pick_len());
        n++;
      end else if (r < 80) begin
        it = rand_encode();
        n++;
      end else if (r < 93) begin
        // flush with random content in the unused fields
        it = make_item(OP_FLUSH, $urandom_range(0, 255), $urandom(), LEN_W'($urandom()));
        n++;
      end else begin
        it = make_item(OP_SPARE, $urandom_range(0, 255), $urandom(), LEN_W'($urandom()));
      end
      // during the hold-off keep offering encodes back to back
      if (hold_req && !hold_done)
        send_item(rand_encode(), 0);
      else
        send_item(it, idle_len());
    end
    item_valid <= 1'b0;

    // drain, then run on idle to catch any stray byte
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d item transactions, %0d bytes checked (%0d flush bytes)",
             items_in, sb.bytes_seen, sb.last_seen);
    $display("tb_top: %0d cycles with the item channel held off, %0d loaded symbols",
             input_stalls, loaded_syms.size());
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== huffman_code_bit_packer_unit.f =====
design/hcbp_pkg.sv
design/hcbp_front.sv
design/hcbp_queue.sv
design/hcbp_back.sv
design/huffman_code_bit_packer_unit.sv
dv/tb_top.sv
